@@ hw/rtl/mmch_pkg.sv @@
`timescale 1ns / 1ps
package mmch_pkg;

   localparam int CORDIC_STEPS    = 16;
   localparam int SCALE_FRAC_BITS = 16;
   localparam int RAW_W   = 16;
   localparam int BIAS_W  = 17;
   localparam int SCALE_W = 24;
   localparam int OUT_W   = 24;
   localparam int HEAD_W  = 17;
   localparam int ANG_W   = 26;
   localparam int CW      = OUT_W + 3;
   localparam int NUM_AXES = 3;
   localparam int IDX_W   = 3;
   localparam int SUM_W   = 20;
   localparam int DIVN_W  = SUM_W + SCALE_FRAC_BITS;
   localparam int DIVD_W  = 20;
   localparam logic [ANG_W-1:0] DEG360 = ANG_W'(360 * 65536);
   localparam logic [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);

   localparam logic [IDX_W-1:0] REG_X_MIN = 3'd0;
   localparam logic [IDX_W-1:0] REG_X_MAX = 3'd1;
   localparam logic [IDX_W-1:0] REG_Y_MIN = 3'd2;
   localparam logic [IDX_W-1:0] REG_Y_MAX = 3'd3;
   localparam logic [IDX_W-1:0] REG_Z_MIN = 3'd4;
   localparam logic [IDX_W-1:0] REG_Z_MAX = 3'd5;

   typedef struct packed {
      logic signed [BIAS_W-1:0]  bias;
      logic        [SCALE_W-1:0] scale;
   } axis_cal_type;

   typedef struct packed {
      logic                     vld;
      logic                     bad;
      logic signed [OUT_W-1:0]  cx;
      logic signed [OUT_W-1:0]  cy;
      logic signed [OUT_W-1:0]  cz;
   } lane_out_type;

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic [ANG_W-1:0] atan_tab(input int i);
      logic [ANG_W-1:0] v;
      v = '0;
      unique case (i)
         0: v = 26'd2949120;   1: v = 26'd1740967;   2: v = 26'd919879;
         3: v = 26'd466945;    4: v = 26'd234379;    5: v = 26'd117304;
         6: v = 26'd58666;     7: v = 26'd29335;     8: v = 26'd14668;
         9: v = 26'd7334;     10: v = 26'd3667;     11: v = 26'd1833;
         12: v = 26'd917;     13: v = 26'd458;      14: v = 26'd229;
         15: v = 26'd115;     16: v = 26'd57;       17: v = 26'd29;
         18: v = 26'd14;      19: v = 26'd7;        20: v = 26'd4;
         21: v = 26'd2;       22: v = 26'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/mmch_scale_div.sv @@
`timescale 1ns / 1ps
module mmch_scale_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic [mmch_pkg::DIVN_W-1:0]        num,
   input  logic [mmch_pkg::DIVD_W-1:0]        den,
   output logic                               done,
   output logic [mmch_pkg::SCALE_W-1:0]       quo
);
   import mmch_pkg::*;

   localparam int CNT_W = $clog2(DIVN_W + 1);

   logic [DIVN_W-1:0] num_ff, num_in;
   logic [DIVD_W:0]   rem_ff, rem_in;
   logic [DIVN_W-1:0] q_ff, q_in;
   logic [DIVD_W-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIVD_W+1:0] trial;

   // restoring divider, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, num_ff[DIVN_W-1]} - {2'b00, den_ff};
      num_in  = {num_ff[DIVN_W-2:0], 1'b0};
      rem_in  = trial[DIVD_W+1] ? {rem_ff[DIVD_W-1:0], num_ff[DIVN_W-1]} : trial[DIVD_W:0];
      q_in    = {q_ff[DIVN_W-2:0], ~trial[DIVD_W+1]};
      cnt_in  = cnt_ff - 1'b1;
      busy_in = busy_ff && (cnt_ff != CNT_W'(1));
      done_in = busy_ff && (cnt_ff == CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (go) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      if (go) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         q_ff   <= '0;
         cnt_ff <= CNT_W'(DIVN_W);
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         q_ff   <= q_in;
         cnt_ff <= cnt_in;
      end
   end

   assign done = done_ff;
   // saturate to 24 bits
   assign quo  = (|q_ff[DIVN_W-1:SCALE_W]) ? {SCALE_W{1'b1}} : q_ff[SCALE_W-1:0];
endmodule

@@ hw/rtl/mmch_lane.sv @@
`timescale 1ns / 1ps
module mmch_lane (
   input  logic                               clock,
   input  logic                               vld,
   input  logic signed [mmch_pkg::RAW_W-1:0]  raw,
   input  mmch_pkg::axis_cal_type             cal,
   output logic signed [mmch_pkg::OUT_W-1:0]  cal_out
);
   import mmch_pkg::*;

   localparam int SH = SCALE_FRAC_BITS - 4;
   localparam int PW = SCALE_W + BIAS_W + 2;

   logic signed [BIAS_W:0]  diff_ff;
   logic        [SCALE_W-1:0] scale_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    prod_in;
   logic        [PW-1:0]    mag;
   logic        [PW-1:0]    rnd;
   logic signed [OUT_W-1:0] res_ff, res_in;

   // stage 1: subtract bias
   always_ff @(posedge clock) begin
      if (vld) begin
         diff_ff  <= (BIAS_W+1)'(raw) - (BIAS_W+1)'(cal.bias);
         scale_ff <= cal.scale;
      end
   end

   // stage 2: multiply
   assign prod_in = $signed({1'b0, scale_ff}) * diff_ff;
   always_ff @(posedge clock) prod_ff <= prod_in;

   // stage 3: round half away from zero and saturate
   always_comb begin
      mag = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
      rnd = (mag + (PW'(1) << (SH - 1))) >> SH;
      if (prod_ff[PW-1])
         res_in = (rnd > PW'(8388608)) ? OUT_W'(24'h800000) : OUT_W'(-rnd);
      else
         res_in = (rnd > PW'(8388607)) ? OUT_W'(24'h7FFFFF) : OUT_W'(rnd);
   end
   always_ff @(posedge clock) res_ff <= res_in;

   assign cal_out = res_ff;
endmodule

@@ hw/rtl/mmch_cordic.sv @@
`timescale 1ns / 1ps
module mmch_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  mmch_pkg::lane_out_type             lin,
   output logic                               vld,
   output logic signed [mmch_pkg::OUT_W-1:0]  cx,
   output logic signed [mmch_pkg::OUT_W-1:0]  cy,
   output logic signed [mmch_pkg::OUT_W-1:0]  cz,
   output logic        [mmch_pkg::HEAD_W-1:0] heading,
   output logic                               bad
);
   import mmch_pkg::*;

   localparam int NS = CORDIC_STEPS;

   // per stage: vector, angle, special-case result
   logic               v_ff  [NS+1];
   logic               b_ff  [NS+1];
   logic               sp_ff [NS+1];
   logic [HEAD_W-1:0]  sh_ff [NS+1];
   logic signed [CW-1:0]   x_ff [NS+1];
   logic signed [CW-1:0]   y_ff [NS+1];
   logic signed [ANG_W:0]  z_ff [NS+1];
   logic signed [OUT_W-1:0] ox_ff [NS+1];
   logic signed [OUT_W-1:0] oy_ff [NS+1];
   logic signed [OUT_W-1:0] oz_ff [NS+1];
   logic signed [ANG_W:0]   zw;
   logic [ANG_W:0]          hr;

   // stage 0: axis cases and half-plane turn
   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= lin.vld;
      b_ff[0]  <= lin.bad;
      ox_ff[0] <= lin.cx;
      oy_ff[0] <= lin.cy;
      oz_ff[0] <= lin.cz;
      sp_ff[0] <= (lin.cy == '0) || (lin.cx == '0);
      if (lin.cy == '0)
         sh_ff[0] <= lin.cx[OUT_W-1] ? HEAD_W'(180 * 256) : '0;
      else
         sh_ff[0] <= lin.cy[OUT_W-1] ? HEAD_W'(270 * 256) : HEAD_W'(90 * 256);
      if (lin.cx[OUT_W-1]) begin
         x_ff[0] <= -CW'(lin.cx);
         y_ff[0] <= -CW'(lin.cy);
         z_ff[0] <= (ANG_W+1)'(DEG180);
      end else begin
         x_ff[0] <= CW'(lin.cx);
         y_ff[0] <= CW'(lin.cy);
         z_ff[0] <= '0;
      end
   end

   // micro-rotation stages
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else       v_ff[i+1] <= v_ff[i];
         b_ff[i+1]  <= b_ff[i];
         sp_ff[i+1] <= sp_ff[i];
         sh_ff[i+1] <= sh_ff[i];
         ox_ff[i+1] <= ox_ff[i];
         oy_ff[i+1] <= oy_ff[i];
         oz_ff[i+1] <= oz_ff[i];
         if (!y_ff[i][CW-1]) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + (ANG_W+1)'(atan_tab(i));
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - (ANG_W+1)'(atan_tab(i));
         end
      end
   end

   // wrap into [0, 360) and round
   always_comb begin
      zw = z_ff[CORDIC_STEPS];
      if (zw[ANG_W]) zw = zw + (ANG_W+1)'(DEG360);
      if (zw >= $signed((ANG_W+1)'(DEG360))) zw = zw - (ANG_W+1)'(DEG360);
      hr = (zw + (ANG_W+1)'(128)) >> 8;
   end

   logic              vo_ff, bo_ff;
   logic [HEAD_W-1:0] ho_ff, ho_in;
   logic signed [OUT_W-1:0] xo_ff, yo_ff, zo_ff;

   always_comb begin
      if (b_ff[CORDIC_STEPS])       ho_in = '0;
      else if (sp_ff[CORDIC_STEPS]) ho_in = sh_ff[CORDIC_STEPS];
      else if (hr >= (ANG_W+1)'(92160)) ho_in = '0;
      else                          ho_in = hr[HEAD_W-1:0];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else       vo_ff <= v_ff[CORDIC_STEPS];
      bo_ff <= b_ff[CORDIC_STEPS];
      ho_ff <= ho_in;
      xo_ff <= b_ff[CORDIC_STEPS] ? '0 : ox_ff[CORDIC_STEPS];
      yo_ff <= b_ff[CORDIC_STEPS] ? '0 : oy_ff[CORDIC_STEPS];
      zo_ff <= b_ff[CORDIC_STEPS] ? '0 : oz_ff[CORDIC_STEPS];
   end

   assign vld = vo_ff;
   assign bad = bo_ff;
   assign heading = ho_ff;
   assign cx = xo_ff;
   assign cy = yo_ff;
   assign cz = zo_ff;
endmodule

@@ hw/rtl/magnetometer_minmax_calibration_heading.sv @@
`timescale 1ns / 1ps
// channel   ports                                        direction
// request   start, busy, req_raw_x/y/z                   in (busy out)
// result    rsp_valid, rsp_cal_x/y/z, rsp_heading,       out
//           rsp_invalid
// config    csr_we, csr_index, csr_wdata                 in
//
// one sample accepted per cycle while busy is low; its result is registered
// in the three lane stages, CORDIC stage 0, the rotation pipeline and the
// output register. after reset and after each min/max register write the
// scale divider runs for each axis, one quotient bit a cycle, with busy high.
// the receiver cannot stall: rsp_valid marks each result for one cycle.
module magnetometer_minmax_calibration_heading (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [mmch_pkg::RAW_W-1:0]   req_raw_x,
   input  logic signed [mmch_pkg::RAW_W-1:0]   req_raw_y,
   input  logic signed [mmch_pkg::RAW_W-1:0]   req_raw_z,
   output logic                                rsp_valid,
   output logic signed [mmch_pkg::OUT_W-1:0]   rsp_cal_x,
   output logic signed [mmch_pkg::OUT_W-1:0]   rsp_cal_y,
   output logic signed [mmch_pkg::OUT_W-1:0]   rsp_cal_z,
   output logic        [mmch_pkg::HEAD_W-1:0]  rsp_heading,
   output logic                                rsp_invalid,
   input  logic                                csr_we,
   input  logic        [mmch_pkg::IDX_W-1:0]   csr_index,
   input  logic        [mmch_pkg::RAW_W-1:0]   csr_wdata
);
   import mmch_pkg::*;

   logic signed [RAW_W-1:0] mn_ff [NUM_AXES];
   logic signed [RAW_W-1:0] mx_ff [NUM_AXES];
   axis_cal_type            cal_ff [NUM_AXES];
   logic                    bad_ff;
   logic [1:0]              ax_ff;
   logic                    go_ff, run_ff;
   logic                    div_done;
   logic [SCALE_W-1:0]      div_q;
   logic [DIVN_W-1:0]       div_num;
   logic [DIVD_W-1:0]       div_den;
   logic signed [RAW_W:0]   span [NUM_AXES];
   logic signed [RAW_W:0]   bsum [NUM_AXES];
   logic                    span_bad;
   logic [SUM_W-1:0]        ssum;
   logic                    acc;
   logic                    csr_hit;

   // spans, biases and the divider operands
   always_comb begin
      span_bad = 1'b0;
      ssum     = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         span[a] = (RAW_W+1)'(mx_ff[a]) - (RAW_W+1)'(mn_ff[a]);
         bsum[a] = (RAW_W+1)'(mx_ff[a]) + (RAW_W+1)'(mn_ff[a]);
         if (span[a] <= 0) span_bad = 1'b1;
         ssum = ssum + SUM_W'(span[a]);
      end
      div_num = {ssum, {SCALE_FRAC_BITS{1'b0}}};
      div_den = DIVD_W'(span[ax_ff]) * DIVD_W'(3);
   end

   assign csr_hit = csr_we && (csr_index <= REG_Z_MAX);

   // register file and scale recompute sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            mn_ff[a] <= 16'sh8000;
            mx_ff[a] <= 16'sh7FFF;
         end
         go_ff  <= 1'b1;
         run_ff <= 1'b1;
         ax_ff  <= '0;
         bad_ff <= 1'b0;
      end else begin
         go_ff <= 1'b0;
         if (csr_hit) begin
            if (csr_index[0]) mx_ff[csr_index[2:1]] <= csr_wdata;
            else              mn_ff[csr_index[2:1]] <= csr_wdata;
            go_ff  <= 1'b1;
            run_ff <= 1'b1;
            ax_ff  <= '0;
         end else if (div_done && !go_ff) begin
            // a done that meets a restart belongs to an aborted run
            cal_ff[ax_ff].scale <= span_bad ? '0 : div_q;
            if (ax_ff == 2'd2) begin
               run_ff <= 1'b0;
               bad_ff <= span_bad;
            end else begin
               ax_ff <= ax_ff + 1'b1;
               go_ff <= 1'b1;
            end
         end
         for (int a = 0; a < NUM_AXES; a++)
            cal_ff[a].bias <= BIAS_W'(bsum[a] / 2);
      end
   end

   mmch_scale_div u_div (
      .clock (clock), .reset (reset), .go (go_ff && !csr_hit),
      .num (div_num), .den (div_den), .done (div_done), .quo (div_q)
   );

   assign busy = run_ff || go_ff;
   assign acc  = start && !busy;

   // lanes, one per axis
   logic signed [OUT_W-1:0] lc [NUM_AXES];
   logic signed [RAW_W-1:0] rw [NUM_AXES];
   assign rw[0] = req_raw_x;
   assign rw[1] = req_raw_y;
   assign rw[2] = req_raw_z;
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      mmch_lane u_lane (
         .clock (clock), .vld (acc), .raw (rw[a]), .cal (cal_ff[a]), .cal_out (lc[a])
      );
   end

   // valid and invalid flag alongside the lanes
   logic [2:0] lv_ff, lb_ff;
   always_ff @(posedge clock) begin
      if (reset) lv_ff <= '0;
      else       lv_ff <= {lv_ff[1:0], acc};
      lb_ff <= {lb_ff[1:0], bad_ff};
   end

   lane_out_type lo;
   assign lo.vld = lv_ff[2];
   assign lo.bad = lb_ff[2];
   assign lo.cx  = lc[0];
   assign lo.cy  = lc[1];
   assign lo.cz  = lc[2];

   mmch_cordic u_cordic (
      .clock (clock), .reset (reset), .lin (lo), .vld (rsp_valid),
      .cx (rsp_cal_x), .cy (rsp_cal_y), .cz (rsp_cal_z),
      .heading (rsp_heading), .bad (rsp_invalid)
   );
endmodule
